@@ hdl/look_disk_scheduler_core_assert.svh @@
// Assertion macros used by the look disk scheduler top level
`ifndef LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH
`define LOOK_DISK_SCHEDULER_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LDS_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define LDS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define LDS_ASSERT_IMPL(label, clk, rstn, ante, cons)
`define LDS_ASSERT_NEXT(label, clk, rstn, ante, cons)
`endif
`endif

@@ hdl/lds_pkg.sv @@
// Package with shared sizes and control types of the look disk scheduler
`timescale 1ns / 1ps
package lds_pkg;
    localparam int MaxRequests = 64;
    localparam int CylBits     = 16;
    localparam int IdxBits     = $clog2(MaxRequests);
    localparam int CntBits     = $clog2(MaxRequests + 1);
    localparam int SeekBits    = 22;
    localparam logic [SeekBits-1:0] SeekMax = {SeekBits{1'b1}};

    localparam logic [0:0] RegHead = 1'b0;
    localparam logic [0:0] RegDir  = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic                store;     // write incoming cylinder
        logic [IdxBits-1:0]  store_idx;
        logic                rd_en;     // read store entry
        logic [IdxBits-1:0]  rd_idx;
        logic                pass_start; // clear selection for new pass
        logic                pass_cmp;  // compare read data with candidate
        logic                pass_upper; // pass selects among >= head
        logic                pass_asc;  // pick smallest (else largest)
        logic                emit_load; // load output register with candidate
        logic                emit_last;
        logic                emit_ovf;
        logic                cand_clear; // reset seek origin to head
    } lds_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic                found;
        logic [IdxBits-1:0]  found_idx;
    } lds_stat_t;
endpackage

@@ hdl/lds_datapath.sv @@
// Datapath: request memory, selection compare, seek accumulate, output register
`timescale 1ns / 1ps
module lds_datapath
    import lds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CylBits-1:0]  in_cyl,
    input  logic [CylBits-1:0]  head,
    input  logic [MaxRequests-1:0] used,
    input  lds_cmd_t            cmd,
    output lds_stat_t           stat,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [CylBits-1:0]  out_cyl,
    output logic [SeekBits-1:0] out_seek,
    output logic                out_ovf,
    output logic                out_last
);
    logic [CylBits-1:0] mem [MaxRequests];
    logic [CylBits-1:0] rd_data_reg;
    logic [IdxBits-1:0] rd_idx_reg;
    logic               rd_vld_reg;
    logic               found_reg;
    logic [IdxBits-1:0] found_idx_reg;
    logic [CylBits-1:0] best_reg;
    logic [CylBits-1:0] cur_reg;
    logic [SeekBits-1:0] seek_reg;
    logic               out_valid_reg;
    logic [CylBits-1:0] diff;
    logic [SeekBits:0]  sum;
    logic               in_group, better;

    // Write and registered read of the request memory
    always_ff @(posedge aclk) begin
        if (cmd.store) mem[cmd.store_idx] <= in_cyl;
        rd_data_reg <= mem[cmd.rd_idx];
        rd_idx_reg  <= cmd.rd_idx;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) rd_vld_reg <= 1'b0;
        else rd_vld_reg <= cmd.rd_en;
    end

    // Candidate test on the entry read last cycle
    always_comb begin
        in_group = cmd.pass_upper ? (rd_data_reg >= head) : (rd_data_reg < head);
        better   = !found_reg ||
                   (cmd.pass_asc ? (rd_data_reg < best_reg) : (rd_data_reg > best_reg));
    end

    // Hold the best candidate of the current pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg <= 1'b0;
        end else if (cmd.pass_start) begin
            found_reg <= 1'b0;
        end else if (cmd.pass_cmp && rd_vld_reg && !used[rd_idx_reg] && in_group && better) begin
            found_reg     <= 1'b1;
            found_idx_reg <= rd_idx_reg;
            best_reg      <= rd_data_reg;
        end
    end

    // Seek distance from the current head
    assign diff = (best_reg > cur_reg) ? (best_reg - cur_reg) : (cur_reg - best_reg);
    assign sum  = {1'b0, seek_reg} + {{(SeekBits + 1 - CylBits){1'b0}}, diff};

    // Output register; track head and seek across the batch
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            seek_reg      <= '0;
        end else begin
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            if (cmd.pass_start && !cmd.pass_cmp && cmd.store) begin
                seek_reg <= '0;
            end
            if (cmd.emit_load) begin
                out_valid_reg <= 1'b1;
                out_cyl       <= best_reg;
                out_seek      <= sum[SeekBits] ? SeekMax : sum[SeekBits-1:0];
                out_ovf       <= cmd.emit_ovf;
                out_last      <= cmd.emit_last;
                seek_reg      <= cmd.emit_last ? '0 :
                                 (sum[SeekBits] ? SeekMax : sum[SeekBits-1:0]);
                cur_reg       <= cmd.emit_last ? head : best_reg;
            end else if (cmd.cand_clear) begin
                cur_reg <= head;
            end
        end
    end

    assign out_valid      = out_valid_reg;
    assign stat.found     = found_reg;
    assign stat.found_idx = found_idx_reg;
endmodule

@@ hdl/lds_controller.sv @@
// Controller: loads the batch, then runs selection passes over the store
`timescale 1ns / 1ps
module lds_controller
    import lds_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_last,
    input  logic                dir_up,
    input  logic                out_valid,
    input  logic                out_ready,
    input  lds_stat_t           stat,
    output lds_cmd_t            cmd,
    output logic [MaxRequests-1:0] used
);
    typedef enum logic [2:0] {ST_LOAD, ST_START, ST_SCAN, ST_DRAIN, ST_EMIT, ST_WAIT}
        state_t;

    state_t              state_reg;
    logic [CntBits-1:0]  count_reg;
    logic [CntBits-1:0]  scan_reg;
    logic [CntBits-1:0]  emitted_reg;
    logic                dropped_reg;
    logic                group_reg;   // 0 first group, 1 second group
    logic [MaxRequests-1:0] used_reg;
    logic                acc;
    logic                upper;

    assign acc      = in_valid && in_ready;
    assign in_ready = (state_reg == ST_LOAD);
    assign upper    = dir_up ^ group_reg;
    assign used     = used_reg;

    // Command decode; load the output register only when it is free or draining
    always_comb begin
        cmd            = '0;
        cmd.store      = acc && (count_reg < CntBits'(MaxRequests));
        cmd.store_idx  = count_reg[IdxBits-1:0];
        cmd.rd_en      = (state_reg == ST_SCAN);
        cmd.rd_idx     = scan_reg[IdxBits-1:0];
        cmd.pass_start = (state_reg == ST_START);
        cmd.pass_cmp   = (state_reg == ST_SCAN) || (state_reg == ST_DRAIN);
        cmd.pass_upper = upper;
        cmd.pass_asc   = upper;
        cmd.emit_load  = (state_reg == ST_EMIT) && stat.found && (!out_valid || out_ready);
        cmd.emit_last  = (emitted_reg + 1'b1 == count_reg);
        cmd.emit_ovf   = dropped_reg;
        cmd.cand_clear = (state_reg == ST_LOAD) && acc && in_last;
    end

    // State, counters and used marks
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            count_reg   <= '0;
            scan_reg    <= '0;
            emitted_reg <= '0;
            dropped_reg <= 1'b0;
            group_reg   <= 1'b0;
            used_reg    <= '0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (acc) begin
                        if (count_reg < CntBits'(MaxRequests)) count_reg <= count_reg + 1'b1;
                        else dropped_reg <= 1'b1;
                        if (in_last) begin
                            state_reg   <= ST_START;
                            group_reg   <= 1'b0;
                            emitted_reg <= '0;
                            used_reg    <= '0;
                        end
                    end
                end
                ST_START: begin
                    scan_reg  <= '0;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    if (scan_reg + 1'b1 == count_reg) state_reg <= ST_DRAIN;
                    scan_reg <= scan_reg + 1'b1;
                end
                ST_DRAIN: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (!stat.found) begin
                        group_reg <= 1'b1;
                        state_reg <= ST_START;
                    end else if (!out_valid || out_ready) begin
                        used_reg[stat.found_idx] <= 1'b1;
                        emitted_reg <= emitted_reg + 1'b1;
                        if (cmd.emit_last) begin
                            count_reg   <= '0;
                            dropped_reg <= 1'b0;
                            state_reg   <= ST_WAIT;
                        end else begin
                            state_reg <= ST_START;
                        end
                    end else begin
                        state_reg <= ST_EMIT;
                    end
                end
                ST_WAIT: if (!out_valid || out_ready) state_reg <= ST_LOAD;
                default: state_reg <= ST_LOAD;
            endcase
        end
    end
endmodule

@@ hdl/look_disk_scheduler_core.sv @@
// Top level of the LOOK disk scheduler: config registers and stream ports
`timescale 1ns / 1ps
`include "look_disk_scheduler_core_assert.svh"
// Requests load at one transaction per cycle, while the core is in its load
// state, into a 64-entry memory. The transaction marked last starts the
// schedule: for each result the controller sweeps the stored requests through
// the memory read port, one per cycle, selecting the next unserved cylinder;
// each result passes through start, n reads, drain and emit for a batch of n
// requests. When the first group runs out before the second, one extra pass
// finds it empty; after the last result the controller waits until the output
// register is free and then returns to loading. Requests beyond 64 are
// dropped and flagged in every result.
module look_disk_scheduler_core
    import lds_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // cylinder[15:0]
    input  logic        s_tlast,   // last_request
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // served_cylinder[15:0], seek_so_far[37:16], pad
    output logic        m_tuser,   // overflow
    output logic        m_tlast    // last_result
);
    logic [CylBits-1:0]  head_reg;
    logic                dir_reg;
    lds_cmd_t            cmd;
    lds_stat_t           stat;
    logic [MaxRequests-1:0] used;
    logic [CylBits-1:0]  o_cyl;
    logic [SeekBits-1:0] o_seek;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg <= '0;
            dir_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                RegHead: head_reg <= cfg_wdata;
                RegDir:  dir_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    lds_controller u_ctrl (
        .aclk, .aresetn,
        .in_valid(s_tvalid), .in_ready(s_tready), .in_last(s_tlast),
        .dir_up(dir_reg), .out_valid(m_tvalid), .out_ready(m_tready),
        .stat, .cmd, .used
    );

    lds_datapath u_dp (
        .aclk, .aresetn, .in_cyl(s_tdata), .head(head_reg), .used, .cmd, .stat,
        .out_valid(m_tvalid), .out_ready(m_tready), .out_cyl(o_cyl),
        .out_seek(o_seek), .out_ovf(m_tuser), .out_last(m_tlast)
    );

    assign m_tdata = {2'b00, o_seek, o_cyl};

    `LDS_ASSERT_IMPL(a_no_load_while_out, aclk, aresetn, m_tvalid, !s_tready)
    `LDS_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit_load, m_tvalid)
    `LDS_ASSERT_IMPL(a_emit_found, aclk, aresetn, cmd.emit_load, stat.found)
endmodule

@@ tb/look_disk_scheduler_core_tb.sv @@
// Testbench for the LOOK disk scheduler core: directed and random batches with a scoreboard
`timescale 1ns / 1ps
module look_disk_scheduler_core_tb;
    import lds_pkg::*;

    typedef struct {
        logic [15:0] cyl;
        logic [21:0] seek;
        logic        ovf;
        logic        last;
    } service_t;

    // Scoreboard: mirrors the batch store and the registers, predicts the service order
    class look_scoreboard;
        logic [15:0] batch_q[$];
        bit          dropped;
        logic [15:0] head;
        bit          dir_up;
        service_t    service_q[$];
        int          errors;
        int          served;
        int          batches;

        function void set_reg(logic [0:0] idx, logic [15:0] val);
            if (idx == RegHead) head = val;
            else dir_up = val[0];
        endfunction

        function void note_request(logic [15:0] cyl, bit last);
            logic [15:0] srt[$];
            logic [15:0] ord[$];
            int split;
            logic [15:0] cur;
            logic [22:0] seek;
            service_t r;
            if (batch_q.size() < MaxRequests) batch_q.push_back(cyl);
            else dropped = 1;
            if (!last) return;
            srt = batch_q;
            srt.sort();
            split = 0;
            while (split < srt.size() && srt[split] < head) split++;
            if (dir_up) begin
                for (int k = split; k < srt.size(); k++) ord.push_back(srt[k]);
                for (int k = split - 1; k >= 0; k--) ord.push_back(srt[k]);
            end else begin
                for (int k = split - 1; k >= 0; k--) ord.push_back(srt[k]);
                for (int k = split; k < srt.size(); k++) ord.push_back(srt[k]);
            end
            cur = head;
            seek = 0;
            foreach (ord[k]) begin
                seek += (ord[k] > cur) ? ord[k] - cur : cur - ord[k];
                if (seek > 23'(SeekMax)) seek = 23'(SeekMax);
                cur = ord[k];
                r.cyl = ord[k];
                r.seek = seek[21:0];
                r.ovf = dropped;
                r.last = (k == ord.size() - 1);
                service_q.push_back(r);
            end
            batch_q.delete();
            dropped = 0;
            batches++;
        endfunction

        function void check_service(logic [15:0] cyl, logic [21:0] seek, bit ovf, bit last);
            service_t e;
            served++;
            if (service_q.size() == 0) begin
                $display("%0t: unexpected result cyl=%0d seek=%0d", $time, cyl, seek);
                errors++;
                return;
            end
            e = service_q.pop_front();
            if (cyl !== e.cyl || seek !== e.seek || ovf !== e.ovf || last !== e.last) begin
                $display("%0t: mismatch expected cyl=%0d seek=%0d ovf=%0b last=%0b",
                         $time, e.cyl, e.seek, e.ovf, e.last);
                $display("%0t:          actual   cyl=%0d seek=%0d ovf=%0b last=%0b",
                         $time, cyl, seek, ovf, last);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_we = 0;
    logic [0:0]  cfg_index = RegHead;
    logic [15:0] cfg_wdata = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [15:0] s_tdata = 0;
    logic        s_tlast = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [39:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    look_scoreboard sb;
    bit  calm;
    bit  chained;
    int  stall_cycles;
    int  sent;

    look_disk_scheduler_core dut (.*);

    always #5 aclk = ~aclk;

    // Check results at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_service(m_tdata[15:0], m_tdata[37:16], m_tuser, m_tlast);
    end

    // Randomly stall the result side
    always @(negedge aclk) begin
        m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Watchdog on cycles without any transaction
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles > 20000) begin
            $display("look_disk_scheduler_core_tb: FAIL");
            $finish;
        end
    end

    task automatic write_reg(logic [0:0] idx, logic [15:0] val);
        @(negedge aclk);
        cfg_we <= 1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_we <= 0;
    endtask

    // Hold one request until accepted, with random gaps before it; keep valid
    // asserted into the next request of the batch
    task automatic send_request(logic [15:0] cyl, bit last);
        if (!chained) @(negedge aclk);
        while (!calm && $urandom_range(99) < 24) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= cyl;
        s_tlast <= last;
        do @(posedge aclk); while (!s_tready);
        sb.note_request(cyl, last);
        sent++;
        @(negedge aclk);
        chained = !last;
        if (last) s_tvalid <= 0;
    endtask

    // Let the batch drain before touching registers
    task automatic drain;
        while (sb.service_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    function automatic logic [15:0] rand_cyl(logic [15:0] near);
        case ($urandom_range(3))
            0: return 16'($urandom_range(1)) * 16'hFFFF;
            1: return near;
            2: return near + 16'($urandom_range(40)) - 16'd20;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_batch(int n);
        for (int i = 0; i < n; i++)
            send_request(rand_cyl(sb.head), i == n - 1);
    endtask

    initial begin
        int n;
        sb = new();
        sb.head = 0;
        sb.dir_up = 1;
        calm = 0;
        chained = 0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1;

        // Directed: single request, head ties, extremes, both directions
        send_request(16'd0, 1);
        send_request(16'hFFFF, 1);
        drain();
        write_reg(RegHead, 16'd100);
        send_request(16'd100, 0);
        send_request(16'd50, 0);
        send_request(16'd150, 0);
        send_request(16'd99, 0);
        send_request(16'hFFFF, 1);
        drain();
        write_reg(RegDir, 16'd0);
        send_request(16'd100, 0);
        send_request(16'd0, 0);
        send_request(16'd200, 0);
        send_request(16'd50, 1);
        drain();
        write_reg(RegHead, 16'hFFFF);
        send_request(16'hAAAA, 0);
        send_request(16'h5555, 1);
        drain();

        // Overflow: a full store plus dropped requests, last one dropped too
        write_reg(RegDir, 16'd1);
        write_reg(RegHead, 16'd0);
        calm = 1;
        for (int i = 0; i < 67; i++) send_request(16'($urandom), i == 66);
        calm = 0;
        drain();

        // Random batches across register settings
        while (sent < 210) begin
            case ($urandom_range(4))
                0: write_reg(RegHead, 16'd0);
                1: write_reg(RegHead, 16'hFFFF);
                default: write_reg(RegHead, 16'($urandom));
            endcase
            write_reg(RegDir, 16'($urandom));
            calm = ($urandom_range(5) == 0);
            n = ($urandom_range(9) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 8);
            send_batch(n);
            drain();
        end
        calm = 0;

        $display("Covered %0d requests in %0d batches, %0d results checked.",
                 sent, sb.batches, sb.served);
        if (sb.errors == 0 && sb.service_q.size() == 0) begin
            $display("look_disk_scheduler_core_tb: PASS");
        end else begin
            $display("look_disk_scheduler_core_tb: FAIL");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hdl
hdl/lds_pkg.sv
hdl/lds_datapath.sv
hdl/lds_controller.sv
hdl/look_disk_scheduler_core.sv
tb/look_disk_scheduler_core_tb.sv
